// ===== hw/rtl/bitmap_id_allocator_assert.svh =====
`ifndef BITMAP_ID_ALLOCATOR_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_ASSERT_SVH

// Same-cycle implication on clk, off while arst_n is low.
`define BIA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, off while arst_n is low.
`define BIA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bia_pkg.sv =====
`timescale 1ns / 1ps

package bia_pkg;

	// default geometry: 64 chunk words of 64 ids
	localparam int CHUNK_BITS_DEF = 64;
	localparam int NUM_CHUNKS_DEF = 64;

	// field widths
	localparam int MODE_W     = 3;
	localparam int ID_W       = 12;
	localparam int END_W      = 13;
	localparam int CNT_W      = 13;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;

	typedef enum logic [2:0] {
		MODE_ISSUE  = 3'd0,
		MODE_ADD    = 3'd1,
		MODE_REMOVE = 3'd2,
		MODE_GET    = 3'd3,
		MODE_ALLOC  = 3'd4,
		MODE_TRIM   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_RANGE    = 2'd2,
		ST_CONFLICT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ALU_KEEP  = 2'd0,
		ALU_SET   = 2'd1,
		ALU_CLEAR = 2'd2
	} alu_op_t;

	// chunk unit results back to the sequencer
	typedef struct packed {
		logic [6:0] hits;      // set bits of the old word under the mask
		logic       nonzero;   // new word has a set bit
		logic [5:0] low_zero;  // index of the lowest set bit of the old word
	} alu_flags_t;

	// popcount: per byte, then over the bytes
	function automatic logic [6:0] ones64(input logic [63:0] v);
		logic [3:0] part [8];
		logic [6:0] sum;
		sum = '0;
		for (int b = 0; b < 8; b++) begin
			part[b] = '0;
			for (int i = 0; i < 8; i++) begin
				part[b] = part[b] + 4'(v[b*8+i]);
			end
		end
		for (int b = 0; b < 8; b++) begin
			sum = sum + 7'(part[b]);
		end
		return sum;
	endfunction

	// lowest set bit: first nonzero byte, then the bit inside it
	function automatic logic [5:0] first64(input logic [63:0] v);
		logic [2:0] byte_sel;
		logic [7:0] sel_bits;
		logic [2:0] bit_sel;
		byte_sel = '0;
		for (int b = 7; b >= 0; b--) begin
			if (v[b*8 +: 8] != 8'h00) byte_sel = 3'(b);
		end
		sel_bits = v[byte_sel*8 +: 8];
		bit_sel = '0;
		for (int i = 7; i >= 0; i--) begin
			if (sel_bits[i]) bit_sel = 3'(i);
		end
		return {byte_sel, bit_sel};
	endfunction

endpackage

// ===== hw/rtl/bia_ram.sv =====
`timescale 1ns / 1ps

module bia_ram
	import bia_pkg::*;
#(
	parameter int WIDTH = CHUNK_BITS_DEF,
	parameter int DEPTH = NUM_CHUNKS_DEF,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/bia_chunk_alu.sv =====
`timescale 1ns / 1ps

module bia_chunk_alu
	import bia_pkg::*;
#(
	parameter int CHUNK_BITS = CHUNK_BITS_DEF,
	localparam int OFF_W = $clog2(CHUNK_BITS),
	localparam int LW = OFF_W + 1
) (
	input  logic [CHUNK_BITS-1:0] word,
	input  logic [LW-1:0]         lo,
	input  logic [LW-1:0]         hi,
	input  alu_op_t               op,
	output logic [CHUNK_BITS-1:0] new_word,
	output alu_flags_t            flags
);

	logic [CHUNK_BITS-1:0] mask;

	// bits [lo, hi) of the chunk
	always_comb begin
		for (int i = 0; i < CHUNK_BITS; i++) begin
			mask[i] = (LW'(i) >= lo) && (LW'(i) < hi);
		end
	end

	// set or clear under the mask
	always_comb begin
		unique case (op)
			ALU_SET:   new_word = word | mask;
			ALU_CLEAR: new_word = word & ~mask;
			ALU_KEEP:  new_word = word;
			default:   new_word = word;
		endcase
	end

	assign flags.hits     = ones64(64'(word & mask));
	assign flags.nonzero  = |new_word;
	assign flags.low_zero = first64(64'(word));

endmodule

// ===== hw/rtl/bitmap_id_allocator.sv =====
`timescale 1ns / 1ps
// Pool of available ids over a window of CHUNK_BITS * NUM_CHUNKS ids.
// s_axis takes one command word: tuser is the mode, tdata holds the id or
// range begin or trim limit and the exclusive range end. m_axis gives one
// result word per command with the status, count, empty flag and minimum.
// Commands run one at a time; s_axis_tready is high only between commands.
// Steps, from accept to result valid:
//   point add/remove/get: two divide steps, one chunk read-modify,
//   minimum search, minimum read; no minimum read when the map ends up empty
//   allocate: search, read, clear, search, read; only the search on an empty map
//   issue range: a check pass, then a set pass, over each chunk touched
//   trim: a clear pass over each chunk below the limit
// Each chunk takes a read step and a modify step on the single chunk RAM;
// the minimum search scans the nonempty flags in groups of 64 chunks.
// s_axis_tready rises with m_axis_tvalid, so the next command can be taken
// in the same cycle that the result shows.
// After reset a clearing pass writes every chunk word before the first command
// is taken. A stalled m_axis holds the finished result in the output register;
// the block may already take the next command and parks at its end until the
// earlier result is taken.

`include "bitmap_id_allocator_assert.svh"

module bitmap_id_allocator
	import bia_pkg::*;
#(
	parameter int CHUNK_BITS = CHUNK_BITS_DEF,
	parameter int NUM_CHUNKS = NUM_CHUNKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [11:0] id_value, [24:12] range_end, [31:25] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [2:0] mode
	input  logic [MODE_W-1:0]     s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [11:0] result_id, [12] bit_found, [14:13] status, [27:15] available_count,
	// [28] map_empty, [40:29] minimum_id, [53:41] trimmed_count, [55:54] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int OFF_W   = $clog2(CHUNK_BITS);
	localparam int LW      = OFF_W + 1;
	localparam int KW      = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int WIN_IDS = CHUNK_BITS * NUM_CHUNKS;
	localparam int AW      = (($clog2(WIN_IDS + 1) > END_W) ? $clog2(WIN_IDS + 1) : END_W) + 1;
	localparam int NG      = (NUM_CHUNKS + 63) / 64;
	localparam int GW      = (NG > 1) ? $clog2(NG) : 1;
	localparam int FPW     = NG * 64;
	localparam int SH      = ID_W + OFF_W;
	localparam int RW      = SH + 1;
	localparam int PW      = ID_W + RW;
	localparam int RECIP   = ((1 << SH) + CHUNK_BITS - 1) / CHUNK_BITS;

	localparam logic [AW-1:0] WIN_A   = AW'(WIN_IDS);
	localparam logic [AW-1:0] CHUNK_A = AW'(CHUNK_BITS);
	localparam logic [LW-1:0] CHUNK_L = LW'(CHUNK_BITS);
	localparam logic [RW-1:0] RECIP_R = RW'(RECIP);
	localparam logic [KW-1:0] LAST_K  = KW'(NUM_CHUNKS - 1);
	localparam logic [GW-1:0] LAST_G  = GW'(NG - 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DIV1, S_DIV2, S_RD, S_MOD, S_FIND, S_MRD, S_MTZ, S_OUT
	} state_t;

	typedef enum logic [2:0] {
		ACT_COUNT, ACT_SET, ACT_CLEAR, ACT_ADD, ACT_REMOVE
	} walk_t;

	state_t                state_q;
	mode_t                 mode_q;
	walk_t                 act_q;
	status_t               status_q;
	logic [ID_W-1:0]       idv_q;
	logic [END_W-1:0]      rend_q;
	logic [ID_W-1:0]       quo_q;
	logic [KW-1:0]         k0_q;
	logic [KW-1:0]         k_q;
	logic [KW-1:0]         fk_q;
	logic [KW-1:0]         clr_q;
	logic [AW-1:0]         base0_q;
	logic [AW-1:0]         base_q;
	logic [AW-1:0]         e_q;
	logic [LW-1:0]         off0_q;
	logic                  first_q;
	logic                  hit_any_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [GW-1:0]         grp_q;
	logic                  alloc_phase_q;
	logic                  found_q;
	logic [ID_W-1:0]       result_id_q;
	logic [CNT_W-1:0]      trimmed_q;
	logic [CNT_W-1:0]      free_q;
	logic [ID_W-1:0]       min_q;
	logic                  has_min_q;
	logic [NUM_CHUNKS-1:0] flags_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// input fields
	mode_t            in_mode;
	logic [ID_W-1:0]  in_idv;
	logic [END_W-1:0] in_rend;
	logic [AW-1:0]    in_idv_a;
	logic [AW-1:0]    in_rend_a;
	logic [AW-1:0]    trim_end;
	logic             in_accept;

	assign in_mode   = mode_t'(s_axis_tuser);
	assign in_idv    = s_axis_tdata[ID_W-1:0];
	assign in_rend   = s_axis_tdata[ID_W +: END_W];
	assign in_idv_a  = AW'(in_idv);
	assign in_rend_a = AW'(in_rend);
	assign trim_end  = (in_idv_a < WIN_A) ? in_idv_a : WIN_A;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	// id -> chunk and offset: reciprocal multiply, then remainder
	logic [PW-1:0]   div_prod;
	logic [ID_W-1:0] div_quo;
	logic [AW-1:0]   div_base;
	logic [LW-1:0]   div_off;

	assign div_prod = PW'(idv_q) * PW'(RECIP_R);
	assign div_quo  = ID_W'(div_prod >> SH);
	assign div_base = AW'(quo_q) * CHUNK_A;
	assign div_off  = LW'(AW'(idv_q) - div_base);

	// chunk RAM and shared chunk unit
	logic                  ram_we;
	logic [KW-1:0]         ram_waddr;
	logic [CHUNK_BITS-1:0] ram_wdata;
	logic [KW-1:0]         ram_raddr;
	logic [CHUNK_BITS-1:0] ram_rdata;
	logic [CHUNK_BITS-1:0] alu_word;
	alu_flags_t            alu_flags;
	alu_op_t               alu_op;
	logic [LW-1:0]         lo;
	logic [LW-1:0]         hi;
	logic [AW-1:0]         diff;
	logic [AW-1:0]         base_next;
	logic                  hit_now;
	logic                  mod_we;
	logic                  walk_done;
	logic [CNT_W-1:0]      cnt_all;

	bia_ram #(
		.WIDTH (CHUNK_BITS),
		.DEPTH (NUM_CHUNKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bia_chunk_alu #(
		.CHUNK_BITS (CHUNK_BITS)
	) u_alu (
		.word     (ram_rdata),
		.lo       (lo),
		.hi       (hi),
		.op       (alu_op),
		.new_word (alu_word),
		.flags    (alu_flags)
	);

	// mask bounds of the current chunk
	assign diff      = e_q - base_q;
	assign hi        = (diff >= CHUNK_A) ? CHUNK_L : diff[LW-1:0];
	assign lo        = first_q ? off0_q : '0;
	assign base_next = base_q + CHUNK_A;
	assign walk_done = base_next >= e_q;
	assign hit_now   = alu_flags.hits != '0;
	assign cnt_all   = cnt_q + CNT_W'(alu_flags.hits);

	always_comb begin
		unique case (act_q)
			ACT_SET, ACT_ADD:      alu_op = ALU_SET;
			ACT_CLEAR, ACT_REMOVE: alu_op = ALU_CLEAR;
			default:               alu_op = ALU_KEEP;
		endcase
	end

	always_comb begin
		unique case (act_q)
			ACT_SET, ACT_CLEAR: mod_we = 1'b1;
			ACT_ADD:            mod_we = !hit_now;
			ACT_REMOVE:         mod_we = hit_now;
			default:            mod_we = 1'b0;
		endcase
	end

	// RAM port control
	always_comb begin
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_MOD: begin
				ram_we    = mod_we;
				ram_waddr = k_q;
				ram_wdata = alu_word;
			end
			default: begin
				ram_we    = 1'b0;
				ram_waddr = k_q;
				ram_wdata = alu_word;
			end
		endcase
	end

	assign ram_raddr = (state_q == S_MRD) ? fk_q : k_q;

	// minimum search over nonempty flags, 64 per cycle
	logic [FPW-1:0]  flag_pad;
	logic [63:0]     flag_grp;
	logic [KW-1:0]   grp_hit;
	logic [AW-1:0]   fbase;
	logic [LW-1:0]   ftz;
	logic [AW-1:0]   fid;

	assign flag_pad = FPW'(flags_q);
	assign flag_grp = flag_pad[grp_q*64 +: 64];
	assign grp_hit  = KW'({grp_q, first64(flag_grp)});
	assign fbase    = AW'(fk_q) * CHUNK_A;
	assign ftz      = LW'(alu_flags.low_zero);
	assign fid      = fbase + AW'(ftz);

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			mode_q        <= MODE_ISSUE;
			act_q         <= ACT_COUNT;
			status_q      <= ST_OK;
			idv_q         <= '0;
			rend_q        <= '0;
			quo_q         <= '0;
			k0_q          <= '0;
			k_q           <= '0;
			fk_q          <= '0;
			clr_q         <= '0;
			base0_q       <= '0;
			base_q        <= '0;
			e_q           <= '0;
			off0_q        <= '0;
			first_q       <= 1'b0;
			hit_any_q     <= 1'b0;
			cnt_q         <= '0;
			grp_q         <= '0;
			alloc_phase_q <= 1'b0;
			found_q       <= 1'b0;
			result_id_q   <= '0;
			trimmed_q     <= '0;
			free_q        <= '0;
			min_q         <= '0;
			has_min_q     <= 1'b0;
			flags_q       <= '0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			// word taken: drop valid unless a new result lands now
			if (out_valid_q && m_axis_tready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_K) state_q <= S_IDLE;
				end

				S_IDLE: begin
					if (in_accept) begin
						mode_q        <= in_mode;
						idv_q         <= in_idv;
						rend_q        <= in_rend;
						found_q       <= 1'b0;
						result_id_q   <= '0;
						trimmed_q     <= '0;
						cnt_q         <= '0;
						hit_any_q     <= 1'b0;
						grp_q         <= '0;
						alloc_phase_q <= in_mode == MODE_ALLOC;
						unique case (in_mode)
							MODE_ISSUE: begin
								if (in_idv_a >= in_rend_a || in_rend_a > WIN_A) begin
									status_q <= ST_RANGE;
									state_q  <= S_FIND;
								end else begin
									status_q <= ST_OK;
									e_q      <= in_rend_a;
									act_q    <= ACT_COUNT;
									state_q  <= S_DIV1;
								end
							end
							MODE_ADD, MODE_REMOVE, MODE_GET: begin
								if (in_idv_a >= WIN_A) begin
									status_q <= ST_RANGE;
									state_q  <= S_FIND;
								end else begin
									status_q <= ST_OK;
									e_q      <= in_idv_a + 1'b1;
									state_q  <= S_DIV1;
									if (in_mode == MODE_ADD) act_q <= ACT_ADD;
									else if (in_mode == MODE_REMOVE) act_q <= ACT_REMOVE;
									else act_q <= ACT_COUNT;
								end
							end
							MODE_ALLOC: begin
								status_q <= ST_OK;
								state_q  <= S_FIND;
							end
							MODE_TRIM: begin
								status_q <= ST_OK;
								e_q      <= trim_end;
								act_q    <= ACT_CLEAR;
								k0_q     <= '0;
								k_q      <= '0;
								base0_q  <= '0;
								base_q   <= '0;
								off0_q   <= '0;
								first_q  <= 1'b1;
								state_q  <= (trim_end == '0) ? S_FIND : S_RD;
							end
							default: begin
								status_q <= ST_OK;
								state_q  <= S_FIND;
							end
						endcase
					end
				end

				S_DIV1: begin
					quo_q   <= div_quo;
					state_q <= S_DIV2;
				end

				S_DIV2: begin
					k0_q    <= quo_q[KW-1:0];
					k_q     <= quo_q[KW-1:0];
					base0_q <= div_base;
					base_q  <= div_base;
					off0_q  <= div_off;
					first_q <= 1'b1;
					state_q <= S_RD;
				end

				S_RD: begin
					state_q <= S_MOD;
				end

				S_MOD: begin
					if (mod_we) flags_q[k_q] <= alu_flags.nonzero;
					if (!walk_done) begin
						cnt_q     <= cnt_all;
						hit_any_q <= hit_any_q | hit_now;
						k_q       <= k_q + 1'b1;
						base_q    <= base_next;
						first_q   <= 1'b0;
						state_q   <= S_RD;
					end else if (act_q == ACT_COUNT && mode_q == MODE_ISSUE
							&& !(hit_any_q || hit_now)) begin
						// range is free: second pass sets it
						act_q     <= ACT_SET;
						k_q       <= k0_q;
						base_q    <= base0_q;
						first_q   <= 1'b1;
						cnt_q     <= '0;
						hit_any_q <= 1'b0;
						state_q   <= S_RD;
					end else begin
						cnt_q     <= cnt_all;
						hit_any_q <= hit_any_q | hit_now;
						state_q   <= S_FIND;
						grp_q     <= '0;
						unique case (act_q)
							ACT_COUNT: begin
								if (mode_q == MODE_ISSUE) status_q <= ST_CONFLICT;
								else found_q <= hit_any_q || hit_now;
							end
							ACT_SET: begin
								free_q <= free_q + CNT_W'(rend_q - END_W'(idv_q));
							end
							ACT_ADD: begin
								if (hit_now) status_q <= ST_CONFLICT;
								else free_q <= free_q + 1'b1;
							end
							ACT_REMOVE: begin
								if (!hit_now) status_q <= ST_CONFLICT;
								else free_q <= free_q - 1'b1;
							end
							ACT_CLEAR: begin
								if (mode_q == MODE_TRIM) begin
									trimmed_q <= cnt_all;
									free_q    <= free_q - cnt_all;
								end else begin
									free_q <= free_q - 1'b1;
								end
							end
							default: begin
								status_q <= ST_OK;
							end
						endcase
					end
				end

				S_FIND: begin
					if (flag_grp != '0) begin
						fk_q    <= grp_hit;
						state_q <= S_MRD;
					end else if (grp_q == LAST_G) begin
						// map empty: no minimum, allocate fails
						if (alloc_phase_q) status_q <= ST_EMPTY;
						alloc_phase_q <= 1'b0;
						has_min_q     <= 1'b0;
						min_q         <= '0;
						state_q       <= S_OUT;
					end else begin
						grp_q <= grp_q + 1'b1;
					end
				end

				S_MRD: begin
					state_q <= S_MTZ;
				end

				S_MTZ: begin
					if (alloc_phase_q) begin
						// hand out the lowest id, then clear it
						result_id_q   <= ID_W'(fid);
						k0_q          <= fk_q;
						k_q           <= fk_q;
						base0_q       <= fbase;
						base_q        <= fbase;
						off0_q        <= ftz;
						first_q       <= 1'b1;
						e_q           <= fid + 1'b1;
						act_q         <= ACT_CLEAR;
						alloc_phase_q <= 1'b0;
						state_q       <= S_RD;
					end else begin
						min_q     <= ID_W'(fid);
						has_min_q <= 1'b1;
						state_q   <= S_OUT;
					end
				end

				S_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {2'b00, trimmed_q, min_q, !has_min_q, free_q,
							status_q, found_q, result_id_q};
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BIA_ASSERT_NEXT(a_accept_starts_step, in_accept, state_q != S_IDLE, "accepted word did not start a step")
	`BIA_ASSERT_SAME(a_result_from_out, $rose(m_axis_tvalid), $past(state_q) == S_OUT, "result shown outside S_OUT")
	`BIA_ASSERT_SAME(a_walk_in_window, state_q == S_RD || state_q == S_MOD, k_q <= LAST_K, "chunk walk left the window")
	`BIA_ASSERT_SAME(a_empty_only_alloc, state_q == S_OUT && status_q == ST_EMPTY, !has_min_q && mode_q == MODE_ALLOC, "empty status without empty allocate")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench
	import bia_pkg::*;
();

	localparam int WINDOW = CHUNK_BITS_DEF * NUM_CHUNKS_DEF;

	// spare opcodes the block must treat as no-ops
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	// one result word, unpacked
	typedef struct packed {
		logic [11:0] result_id;
		logic        bit_found;
		status_t     status;
		logic [12:0] count;
		logic        empty;
		logic [11:0] minimum;
		logic [12:0] trimmed;
	} outcome_t;

	typedef struct {
		logic [2:0]  mode;
		logic [11:0] idv;
		logic [12:0] rend;
		bit          typed;
		outcome_t    want;
	} directed_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [MODE_W-1:0]     s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// mirror of the id pool
	bit [WINDOW-1:0] id_pool;
	logic [12:0]     pool_total;

	outcome_t    pending_q[$];
	bit          failed;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned hold_left;

	directed_row_t directed_rows [0:23] = '{
		// empty map after reset
		'{MODE_ALLOC,    12'd0,    13'd0,    1'b1,
			'{12'd0, 1'b0, ST_EMPTY,    13'd0,    1'b1, 12'd0,    13'd0}},
		'{MODE_GET,      12'd0,    13'd0,    1'b1,
			'{12'd0, 1'b0, ST_OK,       13'd0,    1'b1, 12'd0,    13'd0}},
		'{MODE_REMOVE,   12'd4095, 13'd0,    1'b1,
			'{12'd0, 1'b0, ST_CONFLICT, 13'd0,    1'b1, 12'd0,    13'd0}},
		'{MODE_ISSUE,    12'd5,    13'd5,    1'b1,
			'{12'd0, 1'b0, ST_RANGE,    13'd0,    1'b1, 12'd0,    13'd0}},
		'{MODE_ISSUE,    12'd0,    13'd8191, 1'b1,
			'{12'd0, 1'b0, ST_RANGE,    13'd0,    1'b1, 12'd0,    13'd0}},
		'{MODE_ISSUE,    12'd0,    13'd4097, 1'b1,
			'{12'd0, 1'b0, ST_RANGE,    13'd0,    1'b1, 12'd0,    13'd0}},
		// whole window, then collisions with it
		'{MODE_ISSUE,    12'd0,    13'd4096, 1'b1,
			'{12'd0, 1'b0, ST_OK,       13'd4096, 1'b0, 12'd0,    13'd0}},
		'{MODE_ISSUE,    12'd100,  13'd101,  1'b1,
			'{12'd0, 1'b0, ST_CONFLICT, 13'd4096, 1'b0, 12'd0,    13'd0}},
		'{MODE_ADD,      12'd4095, 13'd0,    1'b1,
			'{12'd0, 1'b0, ST_CONFLICT, 13'd4096, 1'b0, 12'd0,    13'd0}},
		// trim all but the top id, then hand it out
		'{MODE_TRIM,     12'd4095, 13'd0,    1'b1,
			'{12'd0, 1'b0, ST_OK,       13'd1,    1'b0, 12'd4095, 13'd4095}},
		'{MODE_GET,      12'd4095, 13'd0,    1'b1,
			'{12'd0, 1'b1, ST_OK,       13'd1,    1'b0, 12'd4095, 13'd0}},
		'{MODE_ALLOC,    12'd0,    13'd0,    1'b1,
			'{12'd4095, 1'b0, ST_OK,    13'd0,    1'b1, 12'd0,    13'd0}},
		'{MODE_ISSUE,    12'd4095, 13'd4096, 1'b0, '0},
		'{MODE_ADD,      12'd0,    13'd0,    1'b0, '0},
		'{MODE_ISSUE,    12'd1,    13'd64,   1'b0, '0},
		'{MODE_ISSUE,    12'd64,   13'd2000, 1'b0, '0},
		'{MODE_REMOVE,   12'd63,   13'd0,    1'b0, '0},
		'{MODE_SPARE_LO, 12'd1234, 13'd77,   1'b0, '0},
		'{MODE_SPARE_HI, 12'd4095, 13'd8191, 1'b0, '0},
		'{MODE_ALLOC,    12'd0,    13'd0,    1'b0, '0},
		'{MODE_TRIM,     12'd0,    13'd0,    1'b0, '0},
		'{MODE_TRIM,     12'd2048, 13'd0,    1'b0, '0},
		'{MODE_GET,      12'd2047, 13'd0,    1'b0, '0},
		'{MODE_ADD,      12'd2047, 13'd0,    1'b0, '0}
	};

	bitmap_id_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

	// lowest available id at or above start, -1 if none
	function automatic int first_available_from(int start);
		for (int i = start; i < WINDOW; i++) begin
			if (id_pool[i]) return i;
		end
		return -1;
	endfunction

	// applies one command to the mirror and returns its result word
	function automatic outcome_t predict_command(logic [2:0] mode, logic [11:0] idv,
			logic [12:0] rend);
		outcome_t res;
		int       hits;
		int       lo;
		res = '0;
		res.status = ST_OK;
		hits = 0;
		case (mode)
			MODE_ISSUE: begin
				if (idv >= rend || rend > WINDOW) begin
					res.status = ST_RANGE;
				end else begin
					for (int i = idv; i < rend; i++) begin
						if (id_pool[i]) hits++;
					end
					if (hits != 0) begin
						res.status = ST_CONFLICT;
					end else begin
						for (int i = idv; i < rend; i++) id_pool[i] = 1'b1;
						pool_total = pool_total + 13'(rend - idv);
					end
				end
			end
			MODE_ADD: begin
				if (id_pool[idv]) begin
					res.status = ST_CONFLICT;
				end else begin
					id_pool[idv] = 1'b1;
					pool_total++;
				end
			end
			MODE_REMOVE: begin
				if (!id_pool[idv]) begin
					res.status = ST_CONFLICT;
				end else begin
					id_pool[idv] = 1'b0;
					pool_total--;
				end
			end
			MODE_GET: res.bit_found = id_pool[idv];
			MODE_ALLOC: begin
				lo = first_available_from(0);
				if (lo < 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.result_id = 12'(lo);
					id_pool[lo] = 1'b0;
					pool_total--;
				end
			end
			MODE_TRIM: begin
				for (int i = 0; i < idv; i++) begin
					if (id_pool[i]) hits++;
					id_pool[i] = 1'b0;
				end
				res.trimmed = 13'(hits);
				pool_total = pool_total - 13'(hits);
			end
			default: ;
		endcase
		lo = first_available_from(0);
		res.count = pool_total;
		res.empty = (lo < 0);
		res.minimum = (lo < 0) ? 12'd0 : 12'(lo);
		return res;
	endfunction

	// offers one command word, returns once it is taken
	task automatic send_command(logic [2:0] mode, logic [11:0] idv, logic [12:0] rend,
			bit typed, outcome_t typed_want);
		int       gap;
		outcome_t predicted;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < gap_pct) gap++;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {7'd0, rend, idv};
		s_axis_tuser  = mode;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predicted = predict_command(mode, idv, rend);
		pending_q.push_back(typed ? typed_want : predicted);
	endtask

	// mostly commands that succeed on the current pool, some noise
	task automatic send_random_command();
		logic [2:0]  mode;
		logic [11:0] idv;
		logic [12:0] rend;
		int          pick;
		int          b;
		int          e;
		int          cut;
		int          len;
		pick = $urandom_range(99);
		idv  = 12'($urandom);
		rend = 13'($urandom);
		if (pick < 25) begin
			mode = MODE_ISSUE;
			if ($urandom_range(9) != 0) begin
				b = $urandom_range(WINDOW - 1);
				if ($urandom_range(3) != 0) begin
					while (b < WINDOW - 1 && id_pool[b]) b++;
				end
				len = $urandom_range(19);
				if (len < 16) len = $urandom_range(32, 1);
				else if (len < 19) len = $urandom_range(300, 33);
				else len = $urandom_range(WINDOW, 1);
				e = (b + len > WINDOW) ? WINDOW : b + len;
				cut = first_available_from(b);
				if (cut > b && cut < e && $urandom_range(3) != 0) e = cut;
				idv  = 12'(b);
				rend = 13'(e);
			end
		end else if (pick < 40) begin
			mode = MODE_ADD;
		end else if (pick < 65) begin
			mode = (pick < 55) ? MODE_REMOVE : MODE_GET;
			cut = first_available_from(idv);
			if (cut >= 0 && $urandom_range(3) != 0) idv = 12'(cut);
		end else if (pick < 90) begin
			mode = MODE_ALLOC;
		end else if (pick < 97) begin
			mode = MODE_TRIM;
			cut = first_available_from(0);
			if (cut >= 0 && $urandom_range(4) != 0) begin
				cut = cut + $urandom_range(80);
				idv = (cut > WINDOW - 1) ? 12'(WINDOW - 1) : 12'(cut);
			end
		end else begin
			mode = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
		end
		send_command(mode, idv, rend, 1'b0, '0);
	endtask

	// sender goes idle until every expected result has come back
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	// result side ready, with random stalls and forced hold-offs
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else begin
				m_axis_tready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	// compare each taken result word with the oldest expectation
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				$error("result word with no command outstanding");
				failed = 1'b1;
			end else begin
				want = pending_q.pop_front();
				check_field("result_id", want.result_id, m_axis_tdata[11:0]);
				check_field("bit_found", want.bit_found, m_axis_tdata[12]);
				check_field("status", want.status, m_axis_tdata[14:13]);
				check_field("available_count", want.count, m_axis_tdata[27:15]);
				check_field("map_empty", want.empty, m_axis_tdata[28]);
				check_field("minimum_id", want.minimum, m_axis_tdata[40:29]);
				check_field("trimmed_count", want.trimmed, m_axis_tdata[53:41]);
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		id_pool       = '0;
		pool_total    = '0;
		failed        = 1'b0;
		gap_pct       = 0;
		stall_pct     = 0;
		hold_left     = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (directed_rows[i]) begin
			send_command(directed_rows[i].mode, directed_rows[i].idv, directed_rows[i].rend,
				directed_rows[i].typed, directed_rows[i].want);
		end
		wait_drained();

		// random phases: none, sender idle, receiver stall, both
		for (int phase = 0; phase < 4; phase++) begin
			gap_pct   = (phase == 1) ? 78 : (phase == 3) ? 21 : 0;
			stall_pct = (phase == 2) ? 78 : (phase == 3) ? 21 : 0;
			for (int n = 0; n < 112; n++) begin
				// long receiver hold-off while commands keep coming
				if (phase == 0 && n == 30) hold_left = 400;
				send_random_command();
			end
			wait_drained();
		end

		repeat (300) @(posedge clk);
		if (!failed && pending_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
